// ----- sv/assert_macros.svh -----
// Assertion helpers included by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define DIP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define DIP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- sv/dip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_pkg
// Shared types and constants of the double integer power core.
// ----------------------------------------------------------------------------
package dip_pkg;

  localparam int EXPONENT_BITS_DEFAULT = 32;

  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] QNAN_BITS = 64'hFFF8_0000_0000_0000;

  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_DIV,
    FOP_CVT
  } fop_t;

  typedef struct packed {
    logic        start;
    fop_t        op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ival;
    logic        isign;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } fpu_rsp_t;

endpackage

// ----- sv/dip_fpu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_fpu
// Iterative double unit: multiply, reciprocal and integer conversion,
// sharing one normalize / round datapath.
// ----------------------------------------------------------------------------
module dip_fpu (
  input  logic              clk,
  input  logic              rst_n,
  input  dip_pkg::fpu_req_t req,
  output dip_pkg::fpu_rsp_t rsp
);
  import dip_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE, F_MULT, F_DPRE, F_DIVL, F_NORM, F_DENORM, F_ROUND
  } fstate_t;

  fstate_t            state_r;
  logic [127:0]       sig_r;
  logic signed [13:0] e_r;
  logic               sgn_r;
  logic [52:0]        ma_r;
  logic [55:0]        mb_r;
  logic [5:0]         cnt_r;
  logic [53:0]        rem_r;
  logic [63:0]        q_r;
  logic [63:0]        res_r;
  logic               done_r;

  // operand unpack
  logic [10:0] ea, eb, exa, exb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  always_comb begin
    exa    = req.a[62:52];
    exb    = req.b[62:52];
    ea     = (exa == 11'd0) ? 11'd1 : exa;
    eb     = (exb == 11'd0) ? 11'd1 : exb;
    a_nan  = (exa == 11'h7FF) && (req.a[51:0] != 52'd0);
    b_nan  = (exb == 11'h7FF) && (req.b[51:0] != 52'd0);
    a_inf  = (exa == 11'h7FF) && (req.a[51:0] == 52'd0);
    b_inf  = (exb == 11'h7FF) && (req.b[51:0] == 52'd0);
    a_zero = (req.a[62:0] == 63'd0);
    b_zero = (req.b[62:0] == 63'd0);
  end

  // one 53x14 partial product per cycle, top chunk first
  logic [66:0]  prod;
  logic [108:0] acc_nxt;
  always_comb begin
    prod    = ma_r * mb_r[55:42];
    acc_nxt = {sig_r[94:0], 14'd0} + 109'(prod);
  end

  // restoring divide step
  logic        ge;
  logic [53:0] rem_sub, rem_nxt;
  always_comb begin
    ge      = (rem_r >= {1'b0, mb_r[52:0]});
    rem_sub = ge ? (rem_r - {1'b0, mb_r[52:0]}) : rem_r;
    rem_nxt = {rem_sub[52:0], 1'b0};
  end

  // round to nearest even and pack
  logic [52:0]        mant, mf;
  logic [53:0]        mr;
  logic               rg, rs, up, ovf;
  logic signed [13:0] e_fin;
  logic [63:0]        packed_res;
  always_comb begin
    mant  = sig_r[127:75];
    rg    = sig_r[74];
    rs    = |sig_r[73:0];
    up    = rg & (rs | mant[0]);
    mr    = {1'b0, mant} + 54'(up);
    e_fin = mr[53] ? (e_r + 14'sd1) : e_r;
    mf    = mr[53] ? mr[53:1] : mr[52:0];
    ovf   = (e_fin >= 14'sd2047);
    if (ovf) begin
      packed_res = {sgn_r, 11'h7FF, 52'd0};
    end else begin
      packed_res = {sgn_r, (mf[52] ? e_fin[10:0] : 11'd0), mf[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        F_IDLE: begin
          if (req.start) begin
            cnt_r <= '0;
            unique case (req.op)
              FOP_MUL: begin
                sgn_r <= req.a[63] ^ req.b[63];
                if (a_nan) begin
                  res_r  <= req.a | 64'h0008_0000_0000_0000;
                  done_r <= 1'b1;
                end else if (b_nan) begin
                  res_r  <= req.b | 64'h0008_0000_0000_0000;
                  done_r <= 1'b1;
                end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                  res_r  <= QNAN_BITS;
                  done_r <= 1'b1;
                end else if (a_inf || b_inf) begin
                  res_r  <= {req.a[63] ^ req.b[63], 11'h7FF, 52'd0};
                  done_r <= 1'b1;
                end else if (a_zero || b_zero) begin
                  res_r  <= {req.a[63] ^ req.b[63], 63'd0};
                  done_r <= 1'b1;
                end else begin
                  ma_r    <= {exa != 11'd0, req.a[51:0]};
                  mb_r    <= {3'd0, exb != 11'd0, req.b[51:0]};
                  e_r     <= $signed({3'd0, ea}) + $signed({3'd0, eb}) - 14'sd1022;
                  sig_r   <= '0;
                  state_r <= F_MULT;
                end
              end
              FOP_DIV: begin
                sgn_r <= req.b[63];
                if (b_nan) begin
                  res_r  <= req.b | 64'h0008_0000_0000_0000;
                  done_r <= 1'b1;
                end else if (b_inf) begin
                  res_r  <= {req.b[63], 63'd0};
                  done_r <= 1'b1;
                end else if (b_zero) begin
                  res_r  <= {req.b[63], 11'h7FF, 52'd0};
                  done_r <= 1'b1;
                end else begin
                  mb_r    <= {3'd0, exb != 11'd0, req.b[51:0]};
                  e_r     <= $signed({3'd0, eb});
                  state_r <= F_DPRE;
                end
              end
              FOP_CVT: begin
                sgn_r   <= req.isign;
                sig_r   <= {req.ival, 64'd0};
                e_r     <= 14'sd1086;
                state_r <= F_NORM;
              end
              default: state_r <= F_IDLE;
            endcase
          end
        end
        F_MULT: begin
          mb_r  <= {mb_r[41:0], 14'd0};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd3) begin
            sig_r   <= {acc_nxt[105:0], 22'd0};
            state_r <= F_NORM;
          end else begin
            sig_r <= {19'd0, acc_nxt};
          end
        end
        F_DPRE: begin
          // bring a subnormal divisor to a leading one at bit 52
          if (mb_r[52]) begin
            rem_r   <= 54'd1 << 52;
            state_r <= F_DIVL;
          end else begin
            mb_r <= {mb_r[54:0], 1'b0};
            e_r  <= e_r - 14'sd1;
          end
        end
        F_DIVL: begin
          rem_r <= rem_nxt;
          q_r   <= {q_r[62:0], ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            sig_r   <= {q_r[62:0], ge, 63'd0, rem_sub != 54'd0};
            e_r     <= 14'sd2046 - e_r;
            state_r <= F_NORM;
          end
        end
        F_NORM: begin
          if (sig_r[127]) begin
            state_r <= F_DENORM;
          end else begin
            sig_r <= {sig_r[126:0], 1'b0};
            e_r   <= e_r - 14'sd1;
          end
        end
        F_DENORM: begin
          // shift into the subnormal range, folding lost bits into sticky
          if (e_r < 14'sd1) begin
            if (sig_r[127:1] == 127'd0) begin
              e_r     <= 14'sd1;
              state_r <= F_ROUND;
            end else begin
              sig_r <= {1'b0, sig_r[127:2], sig_r[1] | sig_r[0]};
              e_r   <= e_r + 14'sd1;
            end
          end else begin
            state_r <= F_ROUND;
          end
        end
        F_ROUND: begin
          res_r   <= packed_res;
          done_r  <= 1'b1;
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

// ----- sv/double_integer_power_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_integer_power_core
// Double base raised to a signed integer power by square-and-multiply.
// ----------------------------------------------------------------------------
//  channel | signals                              | handshake
//  in      | in_base_bits, in_exponent            | in_valid / in_ready
//  out     | out_result_bits, out_domain_error    | out_valid / out_ready
//
// One transaction at a time through the shared double unit. Each multiply
// runs issue, four 53x14 partial products, normalize, round and handoff; the
// reciprocal for a negative exponent is one restoring-division step per quotient
// bit, plus a shift per leading zero of a subnormal base. A 32-bit exponent
// costs at most 61 multiplies; a zero exponent, or a zero base with a positive
// exponent, needs no multiply, and a subnormal result is shifted step by step.
// in_ready is low from acceptance until the result is loaded into the output
// register; a stalled output holds its transaction. Synchronous reset.
module double_integer_power_core #(
  parameter int EXPONENT_BITS = dip_pkg::EXPONENT_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     in_base_bits,
  input  logic signed [EXPONENT_BITS-1:0] in_exponent,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [63:0]                     out_result_bits,
  output logic                            out_domain_error
);
  import dip_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIVW, S_LOOP, S_MULW, S_CVTW, S_DONE
  } state_t;

  state_t                   state_r;
  logic [63:0]              base_r;
  logic [63:0]              res_r;
  logic [EXPONENT_BITS-1:0] mag_r;
  logic                     derr_r;
  logic                     sq_r;
  fpu_req_t                 req_r;
  fpu_rsp_t                 rsp;
  logic                     out_valid_r;
  logic [63:0]              out_res_r;
  logic                     out_derr_r;

  logic                     neg;
  logic [EXPONENT_BITS-1:0] mag_in;
  logic                     base_zero;
  always_comb begin
    neg       = in_exponent[EXPONENT_BITS-1];
    mag_in    = neg ? (~in_exponent + 1'b1) : in_exponent;
    base_zero = (in_base_bits[62:0] == 63'd0);
  end

  assign in_ready = (state_r == S_IDLE);

  dip_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r.start <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_r.start <= 1'b0;
      // S_DONE reloads the output register itself
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mag_r  <= mag_in;
            base_r <= in_base_bits;
            derr_r <= 1'b0;
            res_r  <= ONE_BITS;
            if (base_zero) begin
              res_r <= 64'd0;
              if (neg || (mag_in == '0)) begin
                derr_r <= 1'b1;
                if (mag_in == '0) begin
                  state_r <= S_DONE;
                end else begin
                  req_r.start <= 1'b1;
                  req_r.op    <= FOP_CVT;
                  req_r.ival  <= 64'(mag_in);
                  req_r.isign <= 1'b1;
                  state_r     <= S_CVTW;
                end
              end else begin
                state_r <= S_DONE;
              end
            end else if (neg) begin
              req_r.start <= 1'b1;
              req_r.op    <= FOP_DIV;
              req_r.b     <= in_base_bits;
              state_r     <= S_DIVW;
            end else begin
              state_r <= S_LOOP;
            end
          end
        end
        S_DIVW: begin
          if (rsp.done) begin
            base_r  <= rsp.result;
            state_r <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (mag_r == '0) begin
            state_r <= S_DONE;
          end else begin
            req_r.start <= 1'b1;
            req_r.op    <= FOP_MUL;
            sq_r        <= ~mag_r[0];
            req_r.a     <= mag_r[0] ? res_r : base_r;
            req_r.b     <= base_r;
            state_r     <= S_MULW;
          end
        end
        S_MULW: begin
          if (rsp.done) begin
            if (sq_r) begin
              base_r <= rsp.result;
              mag_r  <= mag_r >> 1;
            end else begin
              res_r <= rsp.result;
              mag_r <= mag_r - 1'b1;
            end
            state_r <= S_LOOP;
          end
        end
        S_CVTW: begin
          if (rsp.done) begin
            res_r   <= rsp.result;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_res_r   <= res_r;
            out_derr_r  <= derr_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_bits  = out_res_r;
  assign out_domain_error = out_derr_r;

endmodule

// ----- sv/dip_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_checker
// Port-level checks of the double integer power core, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dip_checker #(
  parameter int EXPONENT_BITS = dip_pkg::EXPONENT_BITS_DEFAULT
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [63:0]                     in_base_bits,
  input logic signed [EXPONENT_BITS-1:0] in_exponent,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [63:0]                     out_result_bits,
  input logic                            out_domain_error
);
  // a stalled result holds
  `DIP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_result_bits))
  // a waiting input transaction holds
  `DIP_ASSERT(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable({in_base_bits, in_exponent}))
  // one transaction in flight
  `DIP_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)
  // a domain error carries +0 or a negative integer
  `DIP_ASSERT(a_derr_value, clk, rst_n, out_valid && out_domain_error |-> out_result_bits == 64'd0 || out_result_bits[63])
  // reset empties the output register
  `DIP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind double_integer_power_core dip_checker #(.EXPONENT_BITS(EXPONENT_BITS)) u_dip_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_base_bits     (in_base_bits),
  .in_exponent      (in_exponent),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_bits  (out_result_bits),
  .out_domain_error (out_domain_error)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives base/exponent transactions into double_integer_power_core with random
// gaps and output stalls. Untyped items are checked against a square-and-multiply
// power computed with native double arithmetic; typed rows give their own value.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  EXP_W         = dip_pkg::EXPONENT_BITS_DEFAULT;
  localparam int  RANDOM_ITEMS  = 730;
  localparam int  DRAIN_CYCLES  = 1000;
  localparam longint CYCLE_LIMIT = 20_000_000;

  localparam logic [63:0] POS_ZERO = 64'h0000_0000_0000_0000;
  localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_ONE  = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] TWO      = 64'h4000_0000_0000_0000;
  localparam logic [63:0] MAX_DBL  = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_SUB  = 64'h0000_0000_0000_0001;
  localparam logic signed [EXP_W-1:0] EXP_MIN = {1'b1, {(EXP_W-1){1'b0}}};
  localparam logic signed [EXP_W-1:0] EXP_MAX = {1'b0, {(EXP_W-1){1'b1}}};

  typedef struct {
    logic [63:0]             base;
    logic signed [EXP_W-1:0] expo;
    bit                      typed;   // expected value given in the row
    logic [63:0]             res;
    logic                    derr;
  } stim_row_t;

  typedef struct {
    logic [63:0] res;
    logic        derr;
  } power_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [63:0]             in_base_bits = '0;
  logic signed [EXP_W-1:0] in_exponent = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [63:0]             out_result_bits;
  logic                    out_domain_error;

  power_t    pending_powers[$];
  int        errors = 0;
  longint    cycles = 0;
  bit        steady = 1'b0;   // no new input gaps or output stalls start while set
  int        stall_left = 0;
  stim_row_t rows[$];

  double_integer_power_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_base_bits     (in_base_bits),
    .in_exponent      (in_exponent),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_bits  (out_result_bits),
    .out_domain_error (out_domain_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Square-and-multiply with IEEE double ops; a negative exponent of a nonzero base uses 1/base.
  function automatic power_t int_power(logic [63:0] base_bits,
                                       logic signed [EXP_W-1:0] expo);
    power_t      p;
    logic [EXP_W-1:0] mag;
    bit          neg;
    real         b;
    real         acc;
    neg = expo[EXP_W-1];
    mag = neg ? -expo : expo;
    b = $bitstoreal(base_bits);
    p.derr = 1'b0;
    if (b == 0.0) begin
      if (neg || mag == 0) begin
        p.derr = 1'b1;
        acc = neg ? -real'(mag) : real'(mag);
      end else begin
        acc = 0.0;
      end
    end else begin
      if (neg) b = 1.0 / b;
      acc = 1.0;
      while (mag > 0) begin
        if (!mag[0]) begin
          b = b * b;
          mag = mag >> 1;
        end else begin
          acc = acc * b;
          mag = mag - 1;
        end
      end
    end
    p.res = $realtobits(acc);
    return p;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $time, field, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [63:0] rand_base();
    int r;
    logic [63:0] b;
    r = $urandom_range(0, 99);
    b = {$urandom, $urandom};
    if (r < 45) begin
      // magnitude near 1 so powers stay in range
      b[62:52] = 11'($urandom_range(1013, 1033));
    end else if (r < 55) begin
      case ($urandom_range(0, 5))
        0: b = {b[63], 63'd0};
        1: b = {b[63], 11'h7FF, 52'd0};
        2: b[62:52] = 11'h7FF;
        3: b[62:52] = 11'h000;
        4: b = {b[63], 11'h3FF, 52'd0};
        default: b = {b[63], MAX_DBL[62:0]};
      endcase
    end
    return b;
  endfunction

  function automatic logic signed [EXP_W-1:0] rand_exponent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return EXP_W'($urandom_range(0, 40)) * ($urandom_range(0, 1) ? 1 : -1);
    if (r < 85) return EXP_W'($urandom_range(0, 1100)) * ($urandom_range(0, 1) ? 1 : -1);
    return EXP_W'($urandom);
  endfunction

  task automatic send_item(logic [63:0] base, logic signed [EXP_W-1:0] expo,
                           bit typed, power_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_base_bits <= base;
    in_exponent  <= expo;
    do @(posedge clk); while (!in_ready);
    pending_powers.push_back(typed ? want : int_power(base, expo));
  endtask

  // Output stall generator
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady || $urandom_range(0, 99) < 60) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                : $urandom_range(20, 120);
    end
  end

  // Result checker
  always @(posedge clk) begin
    power_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_powers.size() == 0) begin
        $display("[%0t] unexpected transaction: result %h", $time, out_result_bits);
        errors++;
      end else begin
        want = pending_powers.pop_front();
        if (out_result_bits !== want.res)
          report_mismatch("result_bits", out_result_bits, want.res);
        if (out_domain_error !== want.derr)
          report_mismatch("domain_error", 64'(out_domain_error), 64'(want.derr));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic stim_row_t mk(logic [63:0] b, logic signed [EXP_W-1:0] e,
                                   bit typed = 0, logic [63:0] r = '0, logic d = 0);
    stim_row_t s;
    s.base = b; s.expo = e; s.typed = typed; s.res = r; s.derr = d;
    return s;
  endfunction

  initial begin
    power_t want;
    rows.push_back(mk(POS_ZERO, 5, 1, POS_ZERO, 0));
    rows.push_back(mk(NEG_ZERO, 0, 1, POS_ZERO, 1));
    rows.push_back(mk(POS_ZERO, -3, 1, 64'hC008_0000_0000_0000, 1));
    rows.push_back(mk(NEG_ZERO, EXP_MIN, 1, 64'hC1E0_0000_0000_0000, 1));
    rows.push_back(mk(NEG_ZERO, EXP_MAX, 1, POS_ZERO, 0));
    rows.push_back(mk(dip_pkg::ONE_BITS, 0, 1, dip_pkg::ONE_BITS, 0));
    rows.push_back(mk(dip_pkg::QNAN_BITS, 0, 1, dip_pkg::ONE_BITS, 0));
    rows.push_back(mk(POS_INF, 0, 1, dip_pkg::ONE_BITS, 0));
    rows.push_back(mk(TWO, 10, 1, 64'h4090_0000_0000_0000, 0));
    rows.push_back(mk(TWO, -1, 1, 64'h3FE0_0000_0000_0000, 0));
    rows.push_back(mk(TWO, EXP_MAX, 1, POS_INF, 0));
    rows.push_back(mk(TWO, EXP_MIN, 1, POS_ZERO, 0));
    rows.push_back(mk(NEG_ONE, 3, 1, NEG_ONE, 0));
    rows.push_back(mk(NEG_ONE, EXP_MAX, 1, NEG_ONE, 0));
    rows.push_back(mk(POS_INF, -1, 1, POS_ZERO, 0));
    rows.push_back(mk(MAX_DBL, 2, 1, POS_INF, 0));
    rows.push_back(mk(MIN_SUB, -1, 1, POS_INF, 0));
    rows.push_back(mk(dip_pkg::QNAN_BITS, 3));
    rows.push_back(mk(64'h000F_FFFF_FFFF_FFFF, 1));
    rows.push_back(mk(64'h7FFF_FFFF_FFFF_FFFF, EXP_MAX));
    rows.push_back(mk(64'h3FF8_0000_0000_0000, 7));
    rows.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, -1));
    rows.push_back(mk(64'h4024_0000_0000_0000, -5));
    rows.push_back(mk(64'hBFEF_FFFF_FFFF_FFFF, -EXP_MAX));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      want.res  = rows[i].res;
      want.derr = rows[i].derr;
      send_item(rows[i].base, rows[i].expo, rows[i].typed, want);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // occasional back-to-back stretch
      if (n % 100 == 50) steady = 1'b1;
      if (n % 100 == 70) steady = 1'b0;
      send_item(rand_base(), rand_exponent(), 1'b0, want);
    end
    in_valid <= 1'b0;
    steady   = 1'b0;

    while (pending_powers.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
